### rtl/llh_pkg.sv
// Shared types and constants for the log-linear histogram.
// No dependencies; imported by every module of the block but llh_fifo.
package llh_pkg;

  // fixed field widths
  localparam int VALUE_W = 64;
  localparam int KEY_W   = 12;
  localparam int CFG_W   = 3;

  // precision register reset value
  localparam logic [CFG_W-1:0] SIG_RESET = 3'd6;

  // command codes
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // back end status seen by the top level
  typedef struct packed {
    logic clear_busy;    // counter store is being zeroed
    logic item_pending;  // a memory read is in flight
  } llh_back_stat_t;

endpackage

### rtl/llh_front.sv
// Front end: three-stage pipeline that classifies each transaction,
// maps add samples to bucket keys and computes bucket bounds for gets.
// Depends on llh_pkg.
module llh_front #(
  parameter int MAX_SIG_BITS = 6,
  parameter int ADDR_W       = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [$clog2(MAX_SIG_BITS+1)-1:0]    sig,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [llh_pkg::VALUE_W-1:0]          sample_value,
  input  logic [llh_pkg::VALUE_W-1:0]          increment,
  input  logic [llh_pkg::KEY_W-1:0]            bucket_key,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output logic                                 push_cmd,
  output logic                                 push_err,
  output logic [ADDR_W-1:0]                    push_addr,
  output logic [llh_pkg::VALUE_W-1:0]          push_arg,
  output logic [llh_pkg::VALUE_W-1:0]          push_hi
);
  import llh_pkg::*;

  localparam int SW   = $clog2(MAX_SIG_BITS + 1);
  localparam int MW   = MAX_SIG_BITS + 1;        // mantissa incl. leading one
  localparam int EW   = 7;                       // exponent, 0..64
  localparam int EM_W = EW + MW;
  localparam int WIDE = MAX_SIG_BITS + 8;        // holds any key or bucket count
  localparam int CW   = (WIDE > KEY_W) ? WIDE : KEY_W;

  // leading zeros of a nonzero byte
  function automatic logic [2:0] clz8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 3'(7 - i);
    end
    return n;
  endfunction

  // split a key into exponent and mantissa of its lowest value
  function automatic logic [EM_W-1:0] key_split(input logic [CW-1:0] k,
                                                input logic [SW-1:0] s);
    logic [CW-1:0] size;
    logic [CW-1:0] upper;
    logic [EW-1:0] e;
    logic [MW-1:0] m;
    size  = CW'(1) << s;
    upper = k >> s;
    if (k < size) begin
      e = '0;
      m = MW'(k);
    end else begin
      e = EW'(upper - CW'(1));
      m = MW'(k & (size - CW'(1)) | size);
    end
    return {e, m};
  endfunction

  logic adv;

  // stage A: captured transaction
  logic               a_valid;
  logic               a_cmd;
  logic [VALUE_W-1:0] a_value;
  logic [VALUE_W-1:0] a_inc;
  logic [KEY_W-1:0]   a_key;

  // stage B: byte-wise leading-zero info, range check, bound splits
  logic               b_valid;
  logic               b_cmd;
  logic               b_err;
  logic [VALUE_W-1:0] b_value;
  logic [VALUE_W-1:0] b_inc;
  logic [CW-1:0]      b_key;
  logic [7:0]         b_grp_nz;
  logic [7:0][2:0]    b_grp_lz;
  logic [EM_W-1:0]    b_lo_em;
  logic [EM_W-1:0]    b_hi_em;

  // stage C: exponent resolved
  logic               c_valid;
  logic               c_cmd;
  logic               c_err;
  logic [VALUE_W-1:0] c_value;
  logic [VALUE_W-1:0] c_inc;
  logic [CW-1:0]      c_key;
  logic [EW-1:0]      c_e;
  logic [EM_W-1:0]    c_lo_em;
  logic [EM_W-1:0]    c_hi_em;

  // whole pipeline moves when the last stage is empty or drains
  assign adv      = !c_valid || push_ready;
  assign in_ready = adv;

  // A -> B: forced sample, per-byte leading zeros, get bookkeeping
  logic [VALUE_W-1:0] forced;
  logic [7:0]         grp_nz;
  logic [7:0][2:0]    grp_lz;
  logic [CW-1:0]      key_cw;
  logic [CW-1:0]      buckets;

  always_comb begin
    forced = a_value | (VALUE_W'(1) << sig);
    for (int g = 0; g < 8; g++) begin
      grp_nz[g] = |forced[8*g +: 8];
      grp_lz[g] = clz8(forced[8*g +: 8]);
    end
    key_cw  = CW'(a_key);
    buckets = (CW'(65) - CW'(sig)) << sig;
  end

  // B -> C: leading zeros over the word, then exponent
  logic [EW-1:0] lz;
  logic [EW-1:0] e_calc;

  always_comb begin
    lz = '0;
    for (int g = 0; g < 8; g++) begin
      if (b_grp_nz[g]) lz = EW'(8 * (7 - g)) + EW'(b_grp_lz[g]);
    end
    e_calc = EW'(63) - EW'(sig) - lz;
  end

  // C -> queue: key for adds, bucket bounds for gets
  logic [MW-1:0]      add_m;
  logic [WIDE-1:0]    add_key;
  logic [VALUE_W-1:0] lo_val;
  logic [VALUE_W-1:0] hi_val;

  always_comb begin
    add_m   = MW'(c_value >> c_e);
    add_key = (WIDE'(c_e) << sig) + WIDE'(add_m);
    lo_val  = VALUE_W'(c_lo_em[MW-1:0]) << c_lo_em[EM_W-1:MW];
    hi_val  = (VALUE_W'(c_hi_em[MW-1:0]) << c_hi_em[EM_W-1:MW]) - VALUE_W'(1);
  end

  assign push_valid = c_valid;
  assign push_cmd   = c_cmd;
  assign push_err   = c_err;
  assign push_addr  = (c_cmd == CMD_GET) ? ADDR_W'(c_key) : ADDR_W'(add_key);
  assign push_arg   = (c_cmd == CMD_GET) ? lo_val : c_inc;
  assign push_hi    = hi_val;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd    <= cmd;
      a_value  <= sample_value;
      a_inc    <= increment;
      a_key    <= bucket_key;

      b_cmd    <= a_cmd;
      b_err    <= !(key_cw < buckets);
      b_value  <= a_value;
      b_inc    <= a_inc;
      b_key    <= key_cw;
      b_grp_nz <= grp_nz;
      b_grp_lz <= grp_lz;
      b_lo_em  <= key_split(key_cw, sig);
      b_hi_em  <= key_split(key_cw + CW'(1), sig);

      c_cmd    <= b_cmd;
      c_err    <= b_err;
      c_value  <= b_value;
      c_inc    <= b_inc;
      c_key    <= b_key;
      c_e      <= e_calc;
      c_lo_em  <= b_lo_em;
      c_hi_em  <= b_hi_em;
    end
  end

endmodule

### rtl/llh_fifo.sv
// Small register queue between the front and back ends.
// No package dependencies.
module llh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != NW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      fill <= fill + NW'(1);
      else if (!do_push && do_pop) fill <= fill - NW'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

### rtl/llh_back.sv
// Back end: owns the bucket counter memory, clears it after reset,
// performs read-modify-write for adds and fills the result register for gets.
// Depends on llh_pkg.
module llh_back #(
  parameter int ADDR_W      = 12,
  parameter int STORE_DEPTH = 3776,
  parameter int CNT_W       = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  logic                        q_cmd,
  input  logic                        q_err,
  input  logic [ADDR_W-1:0]           q_addr,
  input  logic [llh_pkg::VALUE_W-1:0] q_arg,
  input  logic [llh_pkg::VALUE_W-1:0] q_hi,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic [llh_pkg::VALUE_W-1:0] bucket_min,
  output logic [llh_pkg::VALUE_W-1:0] bucket_max,
  output logic [llh_pkg::VALUE_W-1:0] bucket_count,
  output llh_pkg::llh_back_stat_t     stat
);
  import llh_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic               cur_cmd;
  logic [ADDR_W-1:0]  cur_addr;
  logic [VALUE_W-1:0] cur_arg;
  logic [VALUE_W-1:0] cur_hi;

  logic [CNT_W-1:0]   counters [STORE_DEPTH];
  logic [CNT_W-1:0]   rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]   mem_wdata;
  logic               mem_re;

  logic               out_free;
  logic               load_err;
  logic               load_hit;

  assign out_free = !out_valid || out_ready;

  // pop when idle: adds never wait for the result register, gets need a free one
  assign q_pop = (state == ST_IDLE) && q_valid && ((q_cmd == CMD_ADD) || out_free);
  assign mem_re   = q_pop && !((q_cmd == CMD_GET) && q_err);
  assign load_err = q_pop && (q_cmd == CMD_GET) && q_err;
  assign load_hit = (state == ST_READ) && (cur_cmd == CMD_GET);

  // memory write mux: clearing pass or add write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = rd_data + cur_arg[CNT_W-1:0];
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if ((state == ST_READ) && (cur_cmd == CMD_ADD)) begin
      mem_we    = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (mem_re) state_next = ST_READ;
      ST_READ:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // current transaction
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd  <= q_cmd;
      cur_addr <= q_addr;
      cur_arg  <= q_arg;
      cur_hi   <= q_hi;
    end
  end

  // counter memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) counters[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= counters[q_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_err || load_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      status       <= STATUS_RANGE;
      bucket_min   <= '0;
      bucket_max   <= '0;
      bucket_count <= '0;
    end else if (load_hit) begin
      status       <= STATUS_OK;
      bucket_min   <= cur_arg;
      bucket_max   <= cur_hi;
      bucket_count <= VALUE_W'(rd_data);
    end
  end

  assign stat.clear_busy   = (state == ST_CLEAR);
  assign stat.item_pending = (state == ST_READ);

endmodule

### rtl/log_linear_histogram.sv
// Log-linear latency histogram: add counts a sample into its bucket, get
// returns one bucket's value range, count and status. After reset the block
// zeroes its counter memory, one entry a cycle, all (65 - MAX_SIG_BITS) *
// 2**MAX_SIG_BITS entries (3776 at defaults), and accepts no transaction
// until done; the precision register may be written meanwhile. A three-stage
// front pipeline takes one transaction a cycle while its two-entry output
// queue has room. The back end reads then writes the counter memory for an
// add, only reads it for an in-range get, and takes no new transaction while
// an access is in flight; an out-of-range get needs no memory access. A get
// reaches out_valid via stages A, B, C, the queue and, if in range, the read.
// Depends on llh_pkg, llh_front, llh_fifo, llh_back.
module log_linear_histogram #(
  parameter int MAX_SIG_BITS = 6,
  parameter int COUNT_WIDTH  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [llh_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [llh_pkg::VALUE_W-1:0] sample_value,
  input  logic [llh_pkg::VALUE_W-1:0] increment,
  input  logic [llh_pkg::KEY_W-1:0]   bucket_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic [llh_pkg::VALUE_W-1:0] bucket_min,
  output logic [llh_pkg::VALUE_W-1:0] bucket_max,
  output logic [llh_pkg::VALUE_W-1:0] bucket_count
);
  import llh_pkg::*;

  localparam int STORE_DEPTH = (65 - MAX_SIG_BITS) << MAX_SIG_BITS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SW          = $clog2(MAX_SIG_BITS + 1);
  localparam int Q_DEPTH     = 2;
  localparam int Q_W         = 2 + ADDR_W + 2 * VALUE_W;

  logic [CFG_W-1:0] sig_cfg;
  logic [SW-1:0]    sig_eff;
  llh_back_stat_t   back_stat;

  logic               front_ready;
  logic               f_valid;
  logic               f_ready;
  logic               f_cmd;
  logic               f_err;
  logic [ADDR_W-1:0]  f_addr;
  logic [VALUE_W-1:0] f_arg;
  logic [VALUE_W-1:0] f_hi;

  logic               q_valid;
  logic               q_pop;
  logic [Q_W-1:0]     q_data;

  // precision register
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_cfg <= SIG_RESET;
    end else if (cfg_wr_en) begin
      sig_cfg <= cfg_wr_data;
    end
  end

  // clamp precision into 1..MAX_SIG_BITS
  always_comb begin
    priority if (sig_cfg == '0) begin
      sig_eff = SW'(1);
    end else if (int'(sig_cfg) > MAX_SIG_BITS) begin
      sig_eff = SW'(MAX_SIG_BITS);
    end else begin
      sig_eff = SW'(sig_cfg);
    end
  end

  // no transactions while the counter store is cleared
  assign in_ready = front_ready && !back_stat.clear_busy;

  llh_front #(
    .MAX_SIG_BITS (MAX_SIG_BITS),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sig          (sig_eff),
    .in_valid     (in_valid && !back_stat.clear_busy),
    .in_ready     (front_ready),
    .cmd          (cmd),
    .sample_value (sample_value),
    .increment    (increment),
    .bucket_key   (bucket_key),
    .push_valid   (f_valid),
    .push_ready   (f_ready),
    .push_cmd     (f_cmd),
    .push_err     (f_err),
    .push_addr    (f_addr),
    .push_arg     (f_arg),
    .push_hi      (f_hi)
  );

  llh_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_cmd, f_err, f_addr, f_arg, f_hi}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  llh_back #(
    .ADDR_W      (ADDR_W),
    .STORE_DEPTH (STORE_DEPTH),
    .CNT_W       (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cmd        (q_data[Q_W-1]),
    .q_err        (q_data[Q_W-2]),
    .q_addr       (q_data[2*VALUE_W +: ADDR_W]),
    .q_arg        (q_data[VALUE_W +: VALUE_W]),
    .q_hi         (q_data[0 +: VALUE_W]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .bucket_min   (bucket_min),
    .bucket_max   (bucket_max),
    .bucket_count (bucket_count),
    .stat         (back_stat)
  );

  // no input taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    back_stat.clear_busy |-> !in_ready)
    else $error("transaction accepted while clearing");

  // clearing pass never restarts once finished
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !back_stat.clear_busy |=> !back_stat.clear_busy)
    else $error("clearing pass restarted");

  // back end does not pop while a memory access is in flight
  a_no_pop_in_read: assert property (@(posedge clk) disable iff (rst)
    back_stat.item_pending |-> !q_pop)
    else $error("queue popped during read-modify-write");

  // range error carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_RANGE)) |->
      ((bucket_min == '0) && (bucket_max == '0) && (bucket_count == '0)))
    else $error("range error result with nonzero fields");

endmodule

### dv/llh_bucket_checker.sv
// Bucket counter predictor and result checker for log_linear_histogram.
// Watches the config port and both valid/ready channels; depends on llh_pkg.
module llh_bucket_checker #(
  parameter int MAX_SIG_BITS = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [llh_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        cmd,
  input  logic [llh_pkg::VALUE_W-1:0] sample_value,
  input  logic [llh_pkg::VALUE_W-1:0] increment,
  input  logic [llh_pkg::KEY_W-1:0]   bucket_key,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        status,
  input  logic [llh_pkg::VALUE_W-1:0] bucket_min,
  input  logic [llh_pkg::VALUE_W-1:0] bucket_max,
  input  logic [llh_pkg::VALUE_W-1:0] bucket_count,
  output int                          mismatches,
  output int                          open_reads
);
  import llh_pkg::*;

  localparam int STORE_DEPTH = (65 - MAX_SIG_BITS) << MAX_SIG_BITS;

  typedef struct {
    logic               status;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [VALUE_W-1:0] count;
  } bucket_reading_t;

  logic [VALUE_W-1:0] model_counts [STORE_DEPTH];
  logic [CFG_W-1:0]   precision_reg = SIG_RESET;
  bucket_reading_t    pending_reads [$];
  int                 mismatch_total = 0;
  int                 reads_open = 0;

  assign mismatches = mismatch_total;
  assign open_reads = reads_open;

  // register value 0 acts as 1, anything above the maximum as the maximum
  function automatic int unsigned clamp_precision(logic [CFG_W-1:0] raw);
    int unsigned s;
    s = raw;
    if (s < 1) s = 1;
    if (s > MAX_SIG_BITS) s = MAX_SIG_BITS;
    return s;
  endfunction

  function automatic int unsigned bucket_total(int unsigned s);
    return (65 - s) << s;
  endfunction

  function automatic int unsigned leading_zeros(logic [VALUE_W-1:0] v);
    int unsigned n;
    n = 0;
    while (n < 64 && !v[63 - n]) n++;
    return n;
  endfunction

  // exponent picks the chunk, the bits under the leading one pick the bucket
  function automatic int unsigned bucket_index(logic [VALUE_W-1:0] v, int unsigned s);
    int unsigned        e;
    logic [VALUE_W-1:0] mant;
    e    = 63 - s - leading_zeros(v | (64'd1 << s));
    mant = v >> e;
    return (e << s) + mant[31:0];
  endfunction

  // smallest value landing in bucket k; wraps to zero one past the top bucket
  function automatic logic [VALUE_W-1:0] bucket_floor(int unsigned k, int unsigned s);
    int unsigned        span;
    int unsigned        e;
    logic [VALUE_W-1:0] mant;
    span = 1 << s;
    if (k < span) return 64'(k);
    e    = (k >> s) - 1;
    mant = 64'(k & (span - 1)) + 64'(span);
    return mant << e;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_total < 100)
      $display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
    mismatch_total++;
  endtask

  always @(posedge clk) begin
    int unsigned     s;
    int unsigned     k;
    bucket_reading_t want;
    if (rst) begin
      foreach (model_counts[i]) model_counts[i] = '0;
      precision_reg = SIG_RESET;
      pending_reads.delete();
    end else begin
      // delivered reading against the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_reads.size() == 0) begin
          report("reading with none outstanding, count", bucket_count, '0);
        end else begin
          want = pending_reads.pop_front();
          if (status !== want.status) report("status", 64'(status), 64'(want.status));
          if (bucket_min !== want.lo) report("bucket_min", bucket_min, want.lo);
          if (bucket_max !== want.hi) report("bucket_max", bucket_max, want.hi);
          if (bucket_count !== want.count) report("bucket_count", bucket_count, want.count);
        end
      end
      // predict the accepted transaction under the current precision
      if (in_valid && in_ready) begin
        s = clamp_precision(precision_reg);
        if (cmd == CMD_ADD) begin
          if (increment != '0) begin
            k = bucket_index(sample_value, s);
            if (k < bucket_total(s)) model_counts[k] += increment;
          end
        end else if (bucket_key < bucket_total(s)) begin
          want.status = STATUS_OK;
          want.lo     = bucket_floor(bucket_key, s);
          want.hi     = bucket_floor(bucket_key + 1, s) - 1;
          want.count  = model_counts[bucket_key];
          pending_reads.push_back(want);
        end else begin
          want.status = STATUS_RANGE;
          want.lo     = '0;
          want.hi     = '0;
          want.count  = '0;
          pending_reads.push_back(want);
        end
      end
      if (cfg_wr_en) precision_reg = cfg_wr_data;
    end
    reads_open <= pending_reads.size();
  end

endmodule

### dv/log_linear_histogram_tb.sv
// Testbench top for log_linear_histogram: directed and random add/get traffic
// across several precisions and idle patterns, verdict from the checker.
// Depends on llh_pkg, log_linear_histogram and llh_bucket_checker.
module log_linear_histogram_tb;
  import llh_pkg::*;

  localparam int MAX_SIG_BITS    = 6;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int SETTLE_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int POOL_SIZE       = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_ADD;
  logic [VALUE_W-1:0] sample_value = '0;
  logic [VALUE_W-1:0] increment = '0;
  logic [KEY_W-1:0]   bucket_key = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic [VALUE_W-1:0] bucket_min;
  logic [VALUE_W-1:0] bucket_max;
  logic [VALUE_W-1:0] bucket_count;

  int mismatches;
  int open_reads;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  // precision register value per phase, and the precision it acts as
  int unsigned phase_raw [PHASES] = '{6, 1, 0, 5, 7, 3, 2, 4, 6};
  int unsigned phase_eff [PHASES] = '{6, 1, 1, 5, 6, 3, 2, 4, 6};

  // buckets revisited during a phase, as exponent and mantissa
  int unsigned pool_e [POOL_SIZE];
  int unsigned pool_m [POOL_SIZE];

  always #2 clk = ~clk;

  log_linear_histogram #(
    .MAX_SIG_BITS(MAX_SIG_BITS),
    .COUNT_WIDTH (64)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .sample_value(sample_value),
    .increment   (increment),
    .bucket_key  (bucket_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .bucket_min  (bucket_min),
    .bucket_max  (bucket_max),
    .bucket_count(bucket_count)
  );

  llh_bucket_checker #(
    .MAX_SIG_BITS(MAX_SIG_BITS)
  ) bucket_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .sample_value(sample_value),
    .increment   (increment),
    .bucket_key  (bucket_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .bucket_min  (bucket_min),
    .bucket_max  (bucket_max),
    .bucket_count(bucket_count),
    .mismatches  (mismatches),
    .open_reads  (open_reads)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[log_linear_histogram] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send(logic c, logic [63:0] v, logic [63:0] inc, logic [11:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    sample_value <= v;
    increment    <= inc;
    bucket_key   <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  // let every read return and the adds behind them retire
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_reads != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned s;
    int unsigned total;
    int unsigned slot;
    int unsigned e;
    int unsigned m;
    int unsigned r;
    int unsigned mode;
    logic [63:0] low;
    logic [63:0] inc;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, wrap, zero increment, ignored fields
    send(CMD_ADD, 64'd0, 64'd1, 12'hFFF);
    send(CMD_ADD, '1, '1, 12'h000);
    send(CMD_ADD, '1, 64'd2, 12'h000);
    send(CMD_ADD, 64'd0, 64'd0, 12'hFFF);
    send(CMD_ADD, 64'd64, 64'd5, '0);
    send(CMD_ADD, 64'd127, 64'd3, '0);
    send(CMD_ADD, 64'd128, 64'd7, '0);
    send(CMD_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 12'h555);
    send(CMD_ADD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 12'hAAA);
    // same bucket back to back
    repeat (3) send(CMD_ADD, 64'd1000, 64'd1, '0);
    send(CMD_GET, '1, '1, 12'd317);
    send(CMD_GET, '0, '0, 12'd0);
    send(CMD_GET, '1, '0, 12'd64);
    send(CMD_GET, '0, '1, 12'd127);
    send(CMD_GET, '1, '1, 12'd128);
    send(CMD_GET, '0, '0, 12'd3733);
    send(CMD_GET, '0, '0, 12'd3669);
    send(CMD_GET, '1, '1, 12'd3775);
    send(CMD_GET, '1, '1, 12'd3776);
    send(CMD_GET, '0, '0, 12'hFFF);
    send(CMD_GET, '0, '0, 12'hAAA);
    send(CMD_GET, '0, '0, 12'h555);

    for (int p = 0; p < PHASES; p++) begin
      // precision changes only once the block is idle
      if (p > 0) begin
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(phase_raw[p]);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
      end
      mode           = p % 4;
      send_idle_pct  = (mode == 1) ? 77 : (mode == 3) ? 16 : 0;
      recv_stall_pct <= (mode == 2) ? 77 : (mode == 3) ? 16 : 0;
      s     = phase_eff[p];
      total = (65 - s) << s;

      // fresh set of buckets to hit repeatedly in this phase
      foreach (pool_e[i]) begin
        pool_e[i] = $urandom_range(63 - s);
        pool_m[i] = (pool_e[i] == 0) ? $urandom_range((2 << s) - 1)
                                     : (1 << s) + $urandom_range((1 << s) - 1);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        slot = $urandom_range(POOL_SIZE - 1);
        e    = pool_e[slot];
        m    = pool_m[slot];
        low  = (e == 0) ? '0 : ({$urandom, $urandom} & ((64'd1 << e) - 1));
        // increments: mostly small, some zero, some huge to force wraps
        r = $urandom_range(99);
        if (r < 15) inc = '0;
        else if (r < 75) inc = $urandom_range(1000, 1);
        else inc = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 45)
          send(CMD_ADD, (64'(m) << e) | low, inc, 12'($urandom));
        else if (r < 60)
          send(CMD_ADD, {$urandom, $urandom} >> $urandom_range(63), inc, 12'($urandom));
        else if (r < 85)
          send(CMD_GET, {$urandom, $urandom}, inc, 12'((e << s) + m));
        else if (r < 93)
          send(CMD_GET, {$urandom, $urandom}, inc, 12'($urandom_range(total - 1)));
        else
          send(CMD_GET, {$urandom, $urandom}, inc, 12'($urandom));
      end
    end

    drain();
    if (mismatches == 0 && open_reads == 0) begin
      $display("[log_linear_histogram] OK");
    end else begin
      $display("[log_linear_histogram] ERROR");
    end
    $finish;
  end

endmodule
